FILE: sv/bmfa_pkg.sv
// shared types and constants of the bitmap first-fit allocator
`default_nettype none
package bmfa_pkg;

   // default pool size in bytes, one map bit per byte
   localparam int PoolBytesDef = 1024;

   // fixed field widths
   localparam int SizeW = 11;
   localparam int OffW  = 10;

   // request kinds
   typedef enum logic [1:0] {
      REQ_ALLOC  = 2'd0,
      REQ_FREE   = 2'd1,
      REQ_RESIZE = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   // result codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_ZERO    = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   // map write control from the sequencer
   typedef struct packed {
      logic wr_en;
      logic wr_bit;
   } map_wr_type;

   // map read data: stored bit and past-the-end flag
   typedef struct packed {
      logic rd_bit;
      logic beyond;
   } map_rd_type;

   // one result item
   typedef struct packed {
      status_type            status;
      logic [OffW-1:0]       offset;
      logic                  moved;
   } result_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EV,
      S_DECIDE,
      S_ROOM_RD,
      S_ROOM_EV,
      S_FIT_RD,
      S_FIT_EV,
      S_WRITE,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: sv/bmfa_map_mem.sv
// occupancy map memory, one bit per byte, registered read
`default_nettype none
module bmfa_map_mem
   import bmfa_pkg::*;
#(
   parameter int POOL_BYTES = PoolBytesDef,
   parameter int AW         = $clog2(PoolBytesDef),
   parameter int CW         = 12
) (
   input  wire logic          clock,
   input  wire logic [CW-1:0] map_addr,
   input  wire map_wr_type    map_wr,
   output map_rd_type         map_rd
);

   logic mem [POOL_BYTES];
   logic rd_ff;
   logic beyond_ff;
   logic in_pool;

   assign in_pool = map_addr < CW'(POOL_BYTES);

   // write port, addresses past the end are dropped
   always_ff @(posedge clock) begin
      if (map_wr.wr_en && in_pool) begin
         mem[map_addr[AW-1:0]] <= map_wr.wr_bit;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_ff     <= mem[map_addr[AW-1:0]];
      beyond_ff <= !in_pool;
   end

   assign map_rd.rd_bit = rd_ff;
   assign map_rd.beyond = beyond_ff;

endmodule
`default_nettype wire

FILE: sv/bmfa_seq.sv
// sequencer: walks the map for search, free, resize and the clearing pass
`default_nettype none
module bmfa_seq
   import bmfa_pkg::*;
#(
   parameter int POOL_BYTES = PoolBytesDef,
   parameter int CW         = 12
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_kind_type    req_kind,
   input  wire logic [SizeW-1:0] req_size,
   input  wire logic [OffW-1:0] req_off,
   output logic [CW-1:0]        map_addr,
   output map_wr_type           map_wr,
   input  wire map_rd_type      map_rd,
   output logic                 res_valid,
   input  wire logic            res_ready,
   output result_type           res_data
);

   state_type     state_ff, state_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] size_ff, size_in;
   logic [CW-1:0] off_ff, off_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] start_ff, start_in;
   logic [1:0]    run_ff, run_in;
   logic          hunt_ff, hunt_in;
   logic          clr_ff, clr_in;
   logic          mv_ff, mv_in;
   logic          wbit_ff, wbit_in;
   req_kind_type  kind_ff, kind_in;
   result_type    result_ff, result_in;

   logic          req_fire;
   logic [CW-1:0] req_size_c;
   logic [CW-1:0] size_eff;
   logic [CW-1:0] req_off_c;
   logic          off_bad;
   logic          scan_more;
   logic          fit_set;
   logic          in_pool;
   logic          fit_hit;
   logic          room_hit;
   logic          cand;
   logic          shrink;
   logic          same;
   logic          last_clr;

   // shared conditions
   assign req_fire   = req_valid && req_ready;
   assign req_size_c = {{(CW-SizeW){1'b0}}, req_size};
   assign size_eff   = (req_size_c <= CW'(1)) ? CW'(2) : req_size_c;
   assign req_off_c  = {{(CW-OffW){1'b0}}, req_off};
   assign off_bad    = req_off_c >= CW'(POOL_BYTES);
   assign scan_more  = map_rd.rd_bit && !map_rd.beyond;
   assign fit_set    = map_rd.rd_bit || map_rd.beyond;
   assign in_pool    = addr_ff < CW'(POOL_BYTES);
   assign fit_hit    = (cnt_ff + CW'(1)) >= size_ff;
   assign room_hit   = (cnt_ff + CW'(1)) >= (size_ff - len_ff - CW'(1));
   assign cand       = !fit_set && (run_ff == 2'd2);
   assign shrink     = (len_ff + CW'(1)) > size_ff;
   assign same       = (len_ff + CW'(1)) == size_ff;
   assign last_clr   = addr_ff == CW'(POOL_BYTES - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (last_clr) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_kind)
                  REQ_ALLOC:  state_in = (req_size_c == '0) ? S_DONE : S_FIT_RD;
                  REQ_FREE,
                  REQ_RESIZE: state_in = off_bad ? S_DONE : S_SCAN_RD;
                  REQ_NONE:   state_in = S_DONE;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_SCAN_RD: state_in = S_SCAN_EV;
         S_SCAN_EV: begin
            if (scan_more)   state_in = S_SCAN_RD;
            else if (clr_ff) state_in = S_DONE;
            else             state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (shrink)    state_in = S_WRITE;
            else if (same) state_in = S_DONE;
            else           state_in = S_ROOM_RD;
         end
         S_ROOM_RD: state_in = S_ROOM_EV;
         S_ROOM_EV: begin
            if (fit_set)       state_in = S_FIT_RD;
            else if (room_hit) state_in = S_WRITE;
            else               state_in = S_ROOM_RD;
         end
         S_FIT_RD: state_in = S_FIT_EV;
         S_FIT_EV: begin
            if (map_rd.beyond)                       state_in = S_DONE;
            else if (!hunt_ff && !fit_set && fit_hit) state_in = S_WRITE;
            else if (hunt_ff && cand && size_ff <= CW'(2)) state_in = S_WRITE;
            else                                      state_in = S_FIT_RD;
         end
         S_WRITE: begin
            if (cnt_ff == '0 || !in_pool) begin
               state_in = (mv_ff && !clr_ff) ? S_SCAN_RD : S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      addr_in   = addr_ff;
      cnt_in    = cnt_ff;
      size_in   = size_ff;
      off_in    = off_ff;
      len_in    = len_ff;
      start_in  = start_ff;
      run_in    = run_ff;
      hunt_in   = hunt_ff;
      clr_in    = clr_ff;
      mv_in     = mv_ff;
      wbit_in   = wbit_ff;
      kind_in   = kind_ff;
      result_in = result_ff;
      map_wr    = '{wr_en: 1'b0, wr_bit: 1'b0};
      req_ready = state_ff == S_IDLE;
      res_valid = state_ff == S_DONE;
      res_data  = result_ff;
      map_addr  = addr_ff;
      unique case (state_ff)
         // clearing pass after reset
         S_CLEAR: begin
            map_wr  = '{wr_en: 1'b1, wr_bit: 1'b0};
            addr_in = addr_ff + CW'(1);
         end
         // take a request
         S_IDLE: begin
            if (req_fire) begin
               kind_in   = req_kind;
               size_in   = size_eff;
               off_in    = req_off_c;
               len_in    = '0;
               cnt_in    = '0;
               run_in    = '0;
               hunt_in   = 1'b0;
               mv_in     = 1'b0;
               start_in  = '0;
               clr_in    = req_kind == REQ_FREE;
               addr_in   = (req_kind == REQ_ALLOC) ? '0 : req_off_c;
               result_in = '{status: ST_OK, offset: '0, moved: 1'b0};
               if (req_kind == REQ_ALLOC && req_size_c == '0) begin
                  result_in.status = ST_ZERO;
               end
               if ((req_kind == REQ_FREE || req_kind == REQ_RESIZE) && off_bad) begin
                  result_in.status = ST_RANGE;
               end
            end
         end
         S_SCAN_RD: ;
         // measure the run, clearing it on a free
         S_SCAN_EV: begin
            if (scan_more) begin
               len_in  = len_ff + CW'(1);
               addr_in = addr_ff + CW'(1);
               if (clr_ff) map_wr = '{wr_en: 1'b1, wr_bit: 1'b0};
            end
         end
         // resize: shrink, keep, or try to grow in place
         S_DECIDE: begin
            if (shrink) begin
               addr_in          = off_ff + size_ff - CW'(1);
               cnt_in           = len_ff + CW'(1) - size_ff;
               wbit_in          = 1'b0;
               result_in.offset = off_ff[OffW-1:0];
            end else if (same) begin
               result_in.offset = off_ff[OffW-1:0];
            end else begin
               addr_in = off_ff + len_ff + CW'(1);
               cnt_in  = '0;
            end
         end
         S_ROOM_RD: ;
         // free bytes after the terminator
         S_ROOM_EV: begin
            if (fit_set) begin
               addr_in  = '0;
               cnt_in   = '0;
               hunt_in  = 1'b0;
               run_in   = '0;
               start_in = '0;
            end else if (room_hit) begin
               addr_in          = off_ff + len_ff;
               cnt_in           = size_ff - len_ff - CW'(1);
               wbit_in          = 1'b1;
               result_in.offset = off_ff[OffW-1:0];
            end else begin
               cnt_in  = cnt_ff + CW'(1);
               addr_in = addr_ff + CW'(1);
            end
         end
         S_FIT_RD: ;
         // first-fit search over candidate starts
         S_FIT_EV: begin
            if (map_rd.beyond) begin
               result_in = '{status: ST_NOSPACE, offset: '0, moved: 1'b0};
            end else if (!hunt_ff) begin
               if (!fit_set && fit_hit) begin
                  addr_in          = start_ff;
                  cnt_in           = size_ff - CW'(1);
                  wbit_in          = 1'b1;
                  result_in.offset = start_ff[OffW-1:0];
                  result_in.moved  = kind_ff == REQ_RESIZE;
                  mv_in            = kind_ff == REQ_RESIZE;
               end else if (!fit_set) begin
                  cnt_in  = cnt_ff + CW'(1);
                  addr_in = addr_ff + CW'(1);
               end else begin
                  hunt_in = 1'b1;
                  run_in  = '0;
                  addr_in = addr_ff + CW'(1);
               end
            end else if (fit_set) begin
               run_in  = '0;
               addr_in = addr_ff + CW'(1);
            end else if (cand) begin
               start_in = addr_ff - CW'(1);
               hunt_in  = 1'b0;
               cnt_in   = CW'(2);
               addr_in  = addr_ff + CW'(1);
               if (size_ff <= CW'(2)) begin
                  addr_in          = addr_ff - CW'(1);
                  cnt_in           = size_ff - CW'(1);
                  wbit_in          = 1'b1;
                  result_in.offset = OffW'(addr_ff - CW'(1));
                  result_in.moved  = kind_ff == REQ_RESIZE;
                  mv_in            = kind_ff == REQ_RESIZE;
               end
            end else begin
               run_in  = run_ff + 2'd1;
               addr_in = addr_ff + CW'(1);
            end
         end
         // write a run of bits, then free the old object after a move
         S_WRITE: begin
            if (cnt_ff != '0 && in_pool) begin
               map_wr  = '{wr_en: 1'b1, wr_bit: wbit_ff};
               addr_in = addr_ff + CW'(1);
               cnt_in  = cnt_ff - CW'(1);
            end else if (mv_ff && !clr_ff) begin
               clr_in  = 1'b1;
               addr_in = off_ff;
               len_in  = '0;
            end
         end
         S_DONE: ;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      size_ff   <= size_in;
      off_ff    <= off_in;
      len_ff    <= len_in;
      start_ff  <= start_in;
      run_ff    <= run_in;
      hunt_ff   <= hunt_in;
      clr_ff    <= clr_in;
      mv_ff     <= mv_in;
      wbit_ff   <= wbit_in;
      kind_ff   <= kind_in;
      result_ff <= result_in;
   end

endmodule
`default_nettype wire

FILE: sv/bitmap_first_fit_allocator_unit.sv
// Bitmap first-fit allocator: a zero size, a range error or an unused kind is answered
// without walking the map; otherwise the sequencer walks map bits and then writes
// the chosen run of bits, and a full search walks the whole map; each map bit costs
// one read plus one check.
// One request at a time; a new transfer is taken while the last result waits.
// After reset a clearing pass writes every map bit before the
// first request is taken.
`default_nettype none
module bitmap_first_fit_allocator_unit
   import bmfa_pkg::*;
#(
   parameter int POOL_BYTES = PoolBytesDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // req_size[10:0], obj_offset[20:11]
   input  wire logic [1:0]  req_tuser,  // req_type[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata   // status[1:0], result_offset[11:2], moved[12]
);

   localparam int AW = $clog2(POOL_BYTES);
   localparam int CW = (AW + 1 > 12) ? AW + 1 : 12;

   logic [CW-1:0] map_addr;
   map_wr_type    map_wr;
   map_rd_type    map_rd;
   logic          res_valid;
   logic          res_ready;
   result_type    res_data;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_data_ff, rsp_data_in;

   bmfa_map_mem #(
      .POOL_BYTES (POOL_BYTES),
      .AW         (AW),
      .CW         (CW)
   ) u_mem (
      .clock    (clock),
      .map_addr (map_addr),
      .map_wr   (map_wr),
      .map_rd   (map_rd)
   );

   bmfa_seq #(
      .POOL_BYTES (POOL_BYTES),
      .CW         (CW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_kind_type'(req_tuser)),
      .req_size  (req_tdata[10:0]),
      .req_off   (req_tdata[20:11]),
      .map_addr  (map_addr),
      .map_wr    (map_wr),
      .map_rd    (map_rd),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff.moved, rsp_data_ff.offset, rsp_data_ff.status};

   // map writes never land past the end of the pool
   assert property (@(posedge clock) disable iff (reset)
      map_wr.wr_en |-> map_addr < CW'(POOL_BYTES))
      else $error("map write past pool end");

   // a handed-over result returns the sequencer to idle
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready |=> req_tready)
      else $error("sequencer did not return to idle");

   // a move is only reported on success
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(res_data.moved && res_data.status != ST_OK))
      else $error("move reported with error status");

endmodule
`default_nettype wire
